[design/bmmh_pkg.sv]
// shared types and constants of the bounded min-max heap
package bmmh_pkg;

  localparam int STATUS_W = 3;
  localparam int FILL_W   = 7;
  localparam int CAP_W    = 7;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  // request codes
  localparam logic FUNC_OFFER = 1'b0;
  localparam logic FUNC_POP   = 1'b1;

  // configuration register indexes
  localparam logic CFG_CAPACITY      = 1'b0;
  localparam logic CFG_KEEP_SMALLEST = 1'b1;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_POP_ROOT, S_POP_LAST, S_POP_INIT, S_INS_FIRST, S_INS_RD,
    S_INS_CMP, S_RISE_RD, S_RISE_CMP, S_REP_A, S_REP_B, S_REP_C, S_REP_D, S_REP_E,
    S_SK_SCAN, S_SK_DEC, S_SK_CHILD, S_SK_PAR, S_DONE
  } ctl_state_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_START, OP_POP_ROOT, OP_POP_LAST, OP_POP_INIT, OP_INS_FIRST, OP_INS_RD,
    OP_INS_CMP, OP_RISE_RD, OP_RISE_CMP, OP_REP_A, OP_REP_B, OP_REP_C, OP_REP_D,
    OP_REP_E, OP_SK_SCAN, OP_SK_DEC, OP_SK_CHILD, OP_SK_PAR, OP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t                op;
    logic [STATUS_W-1:0]   st;
  } dp_cmd_t;

  typedef struct packed {
    logic is_pop;
    logic cnt_zero;
    logic cnt_one;
    logic cnt_two;
    logic below_cap;
    logic issue;
    logic rise_end;
    logic rise_go;
    logic rep_drop;
    logic rep_root;
    logic sk_go;
    logic sk_child;
    logic out_busy;
  } dp_flags_t;

endpackage

[design/bmmh_ram.sv]
// generic simple dual-port ram with registered read
module bmmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/bmmh_ctrl.sv]
// controller state machine sequencing offers, pops and sift passes
module bmmh_ctrl import bmmh_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_flags_t flags,
  output dp_cmd_t   cmd
);

  ctl_state_t          state_r, state_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_INSERTED;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.st    = st_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_START;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (flags.is_pop) begin
          if (flags.cnt_zero) begin
            st_nxt    = ST_EMPTY;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_POP_ROOT;
          end
        end else if (flags.below_cap) begin
          state_nxt = flags.cnt_zero ? S_INS_FIRST : S_INS_RD;
        end else begin
          state_nxt = S_REP_A;
        end
      end
      S_POP_ROOT: begin
        cmd.op    = OP_POP_ROOT;
        state_nxt = S_POP_LAST;
      end
      S_POP_LAST: begin
        cmd.op    = OP_POP_LAST;
        state_nxt = S_POP_INIT;
      end
      S_POP_INIT: begin
        cmd.op    = OP_POP_INIT;
        state_nxt = S_SK_SCAN;
      end
      S_INS_FIRST: begin
        cmd.op    = OP_INS_FIRST;
        st_nxt    = ST_INSERTED;
        state_nxt = S_DONE;
      end
      S_INS_RD: begin
        cmd.op    = OP_INS_RD;
        state_nxt = S_INS_CMP;
      end
      S_INS_CMP: begin
        cmd.op    = OP_INS_CMP;
        state_nxt = S_RISE_RD;
      end
      S_RISE_RD: begin
        cmd.op = OP_RISE_RD;
        if (flags.rise_end) begin
          st_nxt    = ST_INSERTED;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RISE_CMP;
        end
      end
      S_RISE_CMP: begin
        cmd.op = OP_RISE_CMP;
        if (flags.rise_go) begin
          state_nxt = S_RISE_RD;
        end else begin
          st_nxt    = ST_INSERTED;
          state_nxt = S_DONE;
        end
      end
      S_REP_A: begin
        cmd.op    = OP_REP_A;
        state_nxt = S_REP_B;
      end
      S_REP_B: begin
        cmd.op    = OP_REP_B;
        state_nxt = S_REP_C;
      end
      S_REP_C: begin
        cmd.op    = OP_REP_C;
        state_nxt = S_REP_D;
      end
      S_REP_D: begin
        cmd.op = OP_REP_D;
        if (flags.rep_drop) begin
          st_nxt    = ST_DROPPED;
          state_nxt = S_DONE;
        end else if (flags.rep_root) begin
          st_nxt    = ST_REPLACED;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_REP_E;
        end
      end
      S_REP_E: begin
        cmd.op    = OP_REP_E;
        state_nxt = S_SK_SCAN;
      end
      S_SK_SCAN: begin
        cmd.op = OP_SK_SCAN;
        if (!flags.issue) begin
          state_nxt = S_SK_DEC;
        end
      end
      S_SK_DEC: begin
        cmd.op = OP_SK_DEC;
        if (!flags.sk_go) begin
          st_nxt    = flags.is_pop ? ST_POPPED : ST_REPLACED;
          state_nxt = S_DONE;
        end else if (flags.sk_child) begin
          state_nxt = S_SK_CHILD;
        end else begin
          state_nxt = S_SK_PAR;
        end
      end
      S_SK_CHILD: begin
        cmd.op    = OP_SK_CHILD;
        st_nxt    = flags.is_pop ? ST_POPPED : ST_REPLACED;
        state_nxt = S_DONE;
      end
      S_SK_PAR: begin
        cmd.op    = OP_SK_PAR;
        state_nxt = S_SK_SCAN;
      end
      S_DONE: begin
        if (!flags.out_busy) begin
          cmd.op    = OP_LOAD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[design/bmmh_dp.sv]
// datapath: count, config, working registers, comparators and output register
module bmmh_dp import bmmh_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_flags_t                flags,
  input  logic                     in_func,
  input  logic [KEY_WIDTH-1:0]     in_key,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic [KEY_WIDTH-1:0]     out_out_key,
  output logic [FILL_W-1:0]        out_fill,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [CAP_W-1:0]         cfg_data,
  output logic                     ram_we,
  output logic [$clog2(DEPTH)-1:0] ram_waddr,
  output logic [KEY_WIDTH-1:0]     ram_wdata,
  output logic [$clog2(DEPTH)-1:0] ram_raddr,
  input  logic [KEY_WIDTH-1:0]     ram_rdata
);

  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = AW + 3;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [2:0] NCAND = 3'd6;

  // control registers
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CAP_W-1:0] cap_r;
  logic             ks_r;
  logic             out_valid_r;
  logic [2:0]       k_r, k_nxt;
  logic             pend_r, pend_nxt;
  logic             any_r, any_nxt;

  // payload registers
  logic                 func_r, func_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [KEY_WIDTH-1:0] val_r, val_nxt;
  logic [KEY_WIDTH-1:0] best_r, best_nxt;
  logic [KEY_WIDTH-1:0] okey_r, okey_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [AW-1:0]        bidx_r, bidx_nxt;
  logic [AW-1:0]        pidx_r, pidx_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic                 on_max_r, on_max_nxt;
  logic [STATUS_W-1:0]  ostat_r;
  logic [KEY_WIDTH-1:0] okey_out_r;
  logic [FILL_W-1:0]    ofill_r;

  // helpers
  logic [CW-1:0]   cap_x, cap_eff;
  logic [IW-1:0]   iw, g0, cand_w;
  logic [AW-1:0]   cand;
  logic [AW-1:0]   par_cnt, par_idx, par_bidx, gp_idx;
  logic            issue, ins_swap, par_swap, root_swap;

  function automatic logic gt(input logic [KEY_WIDTH-1:0] a, input logic [KEY_WIDTH-1:0] b,
                              input logic ks);
    return ks ? (a < b) : (a > b);
  endfunction

  function automatic logic prefer(input logic [KEY_WIDTH-1:0] a,
                                  input logic [KEY_WIDTH-1:0] b,
                                  input logic om, input logic ks);
    return om ? gt(a, b, ks) : gt(b, a, ks);
  endfunction

  // level parity of a store position: even level holds maxima
  function automatic logic max_level(input logic [AW-1:0] i);
    logic [AW:0] v;
    logic        par;
    v   = {1'b0, i} + 1'b1;
    par = 1'b0;
    for (int b = 0; b <= AW; b++) begin
      if (v[b]) begin
        par = b[0];
      end
    end
    return !par;
  endfunction

  // effective capacity clamp
  always_comb begin
    cap_x   = CW'(cap_r);
    cap_eff = cap_x;
    if (cap_x == '0) begin
      cap_eff = CW'(1);
    end else if (cap_x > CW'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end
  end

  // candidate addresses for the sink scan and tree arithmetic
  always_comb begin
    iw = IW'(idx_r);
    g0 = (iw << 2) + IW'(3);
    case (k_r)
      3'd0:    cand_w = (iw << 1) + IW'(1);
      3'd1:    cand_w = (iw << 1) + IW'(2);
      default: cand_w = g0 + IW'(k_r - 3'd2);
    endcase
    issue    = (k_r < NCAND) && (cand_w < IW'(n_r));
    cand     = cand_w[AW-1:0];
    par_cnt  = AW'((count_r - 1'b1) >> 1);
    par_idx  = AW'((idx_r - 1'b1) >> 1);
    par_bidx = AW'((bidx_r - 1'b1) >> 1);
    gp_idx   = AW'((idx_r - AW'(3)) >> 2);
    ins_swap  = prefer(ram_rdata, key_r, on_max_r, ks_r);
    par_swap  = prefer(ram_rdata, val_r, on_max_r, ks_r);
    root_swap = gt(val_r, ram_rdata, ks_r);
  end

  // status towards the controller
  always_comb begin
    flags.is_pop    = (func_r == FUNC_POP);
    flags.cnt_zero  = (count_r == '0);
    flags.cnt_one   = (count_r == CNT_W'(1));
    flags.cnt_two   = (count_r == CNT_W'(2));
    flags.below_cap = (CW'(count_r) < cap_eff);
    flags.issue     = issue;
    flags.rise_end  = (IW'(idx_r) < IW'(3));
    flags.rise_go   = prefer(val_r, ram_rdata, on_max_r, ks_r);
    flags.rep_drop  = gt(best_r, key_r, ks_r);
    flags.rep_root  = (bidx_r == '0);
    flags.sk_go     = any_r && prefer(best_r, val_r, on_max_r, ks_r);
    flags.sk_child  = (IW'(bidx_r) < g0);
    flags.out_busy  = out_valid_r && !out_ready;
  end

  // per-operation datapath actions
  always_comb begin
    count_nxt  = count_r;
    k_nxt      = k_r;
    pend_nxt   = pend_r;
    any_nxt    = any_r;
    func_nxt   = func_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    best_nxt   = best_r;
    okey_nxt   = okey_r;
    idx_nxt    = idx_r;
    bidx_nxt   = bidx_r;
    pidx_nxt   = pidx_r;
    n_nxt      = n_r;
    on_max_nxt = on_max_r;
    ram_we     = 1'b0;
    ram_waddr  = idx_r;
    ram_wdata  = val_r;
    ram_raddr  = '0;
    case (cmd.op)
      OP_START: begin
        func_nxt = in_func;
        key_nxt  = in_key;
        okey_nxt = '0;
      end
      OP_POP_ROOT: begin
        ram_raddr = '0;
      end
      OP_POP_LAST: begin
        ram_raddr = AW'(count_r - 1'b1);
        okey_nxt  = ram_rdata;
        count_nxt = count_r - 1'b1;
      end
      OP_POP_INIT: begin
        val_nxt    = ram_rdata;
        idx_nxt    = '0;
        n_nxt      = count_r;
        on_max_nxt = 1'b1;
        k_nxt      = '0;
        pend_nxt   = 1'b0;
        any_nxt    = 1'b0;
      end
      OP_INS_FIRST: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = key_r;
        count_nxt = count_r + 1'b1;
      end
      OP_INS_RD: begin
        ram_raddr  = par_cnt;
        idx_nxt    = AW'(count_r);
        on_max_nxt = max_level(AW'(count_r));
        count_nxt  = count_r + 1'b1;
      end
      OP_INS_CMP: begin
        val_nxt = key_r;
        if (ins_swap) begin
          ram_we     = 1'b1;
          ram_waddr  = idx_r;
          ram_wdata  = ram_rdata;
          idx_nxt    = par_idx;
          on_max_nxt = !on_max_r;
        end
      end
      OP_RISE_RD: begin
        ram_raddr = gp_idx;
        if (flags.rise_end) begin
          ram_we = 1'b1;
        end
      end
      OP_RISE_CMP: begin
        ram_we = 1'b1;
        if (flags.rise_go) begin
          ram_wdata = ram_rdata;
          idx_nxt   = gp_idx;
        end
      end
      OP_REP_A: begin
        ram_raddr = flags.cnt_one ? AW'(0) : AW'(1);
        bidx_nxt  = flags.cnt_one ? AW'(0) : AW'(1);
      end
      OP_REP_B: begin
        ram_raddr = AW'(2);
        best_nxt  = ram_rdata;
      end
      OP_REP_C: begin
        // third and later keys: least of the two root children (greatest when keeping the smallest keys)
        if (!flags.cnt_one && !flags.cnt_two && gt(best_r, ram_rdata, ks_r)) begin
          best_nxt = ram_rdata;
          bidx_nxt = AW'(2);
        end
      end
      OP_REP_D: begin
        if (flags.rep_drop) begin
          okey_nxt = key_r;
        end else begin
          okey_nxt = best_r;
          val_nxt  = key_r;
          idx_nxt  = bidx_r;
          if (flags.rep_root) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = key_r;
          end
        end
      end
      OP_REP_E: begin
        if (root_swap) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = val_r;
          val_nxt   = ram_rdata;
        end
        n_nxt      = count_r;
        on_max_nxt = 1'b0;
        k_nxt      = '0;
        pend_nxt   = 1'b0;
        any_nxt    = 1'b0;
      end
      OP_SK_SCAN: begin
        ram_raddr = cand;
        pend_nxt  = issue;
        pidx_nxt  = cand;
        if (issue) begin
          k_nxt = k_r + 1'b1;
        end
        if (pend_r && (!any_r || prefer(ram_rdata, best_r, on_max_r, ks_r))) begin
          best_nxt = ram_rdata;
          bidx_nxt = pidx_r;
          any_nxt  = 1'b1;
        end
      end
      OP_SK_DEC: begin
        ram_we    = 1'b1;
        ram_raddr = par_bidx;
        if (flags.sk_go) begin
          ram_wdata = best_r;
        end
      end
      OP_SK_CHILD: begin
        ram_we    = 1'b1;
        ram_waddr = bidx_r;
      end
      OP_SK_PAR: begin
        if (par_swap) begin
          ram_we    = 1'b1;
          ram_waddr = par_bidx;
          val_nxt   = ram_rdata;
        end
        idx_nxt  = bidx_r;
        k_nxt    = '0;
        pend_nxt = 1'b0;
        any_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CAP_W'(64);
      ks_r        <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      pend_r      <= 1'b0;
      any_r       <= 1'b0;
    end else begin
      count_r <= count_nxt;
      k_r     <= k_nxt;
      pend_r  <= pend_nxt;
      any_r   <= any_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_CAPACITY) begin
          cap_r <= cfg_data;
        end else begin
          ks_r <= cfg_data[0];
        end
      end
      if (cmd.op == OP_LOAD_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    best_r   <= best_nxt;
    okey_r   <= okey_nxt;
    idx_r    <= idx_nxt;
    bidx_r   <= bidx_nxt;
    pidx_r   <= pidx_nxt;
    n_r      <= n_nxt;
    on_max_r <= on_max_nxt;
    if (cmd.op == OP_LOAD_OUT) begin
      ostat_r    <= cmd.st;
      okey_out_r <= (cmd.st == ST_INSERTED || cmd.st == ST_EMPTY) ? '0 : okey_r;
      ofill_r    <= FILL_W'(count_r);
    end
  end

  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_status  = ostat_r;
  assign out_out_key = okey_out_r;
  assign out_fill    = ofill_r;

endmodule

[design/bounded_min_max_heap.sv]
// bounded min-max heap: an insert rises towards the root; a pop or a replacing offer sinks, with
// up to six reads per level on the single read port, a drain step, then two steps to settle.
// one request at a time; the result is held in an output register, so a waiting result does not
// block acceptance of the next request, which only stalls before loading its own result.
// reset (synchronous, active low) empties the heap, sets capacity 64 and keeps the largest keys;
// the key store itself is not cleared.
module bounded_min_max_heap import bmmh_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [KEY_WIDTH-1:0] in_key,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [KEY_WIDTH-1:0] out_out_key,
  output logic [FILL_W-1:0]    out_fill,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [CAP_W-1:0]     cfg_data
);

  localparam int AW = $clog2(DEPTH);

  dp_cmd_t              cmd;
  dp_flags_t            flags;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [KEY_WIDTH-1:0] ram_wdata, ram_rdata;

  // sequencer
  bmmh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .flags    (flags),
    .cmd      (cmd)
  );

  // datapath
  bmmh_dp #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .flags       (flags),
    .in_func     (in_func),
    .in_key      (in_key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_out_key (out_out_key),
    .out_fill    (out_fill),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  // key store
  bmmh_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[design/bmmh_checker.sv]
// port-level checks of the bounded min-max heap and their binding
module bmmh_checker import bmmh_pkg::*; #(
  parameter int KEY_WIDTH = 32
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [STATUS_W-1:0]  out_status,
  input logic [KEY_WIDTH-1:0] out_out_key,
  input logic [FILL_W-1:0]    out_fill
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // one request at a time: no transfer in the cycle after an input transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a request is in progress");

  // status codes stay in range
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_INSERTED || out_status == ST_REPLACED ||
                   out_status == ST_DROPPED || out_status == ST_POPPED ||
                   out_status == ST_EMPTY))
    else $error("bad status code");

  // a pop on an empty heap leaves it empty and returns no key
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_fill == '0 && out_out_key == '0)
    else $error("empty pop with fill or key");

  // an insert returns no key and leaves at least one key
  a_insert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_INSERTED |-> out_out_key == '0 && out_fill != '0)
    else $error("insert result inconsistent");

endmodule

bind bounded_min_max_heap bmmh_checker #(.KEY_WIDTH(KEY_WIDTH)) u_bmmh_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_status  (out_status),
  .out_out_key (out_out_key),
  .out_fill    (out_fill)
);
